FILE: rtl/core/lpht_pkg.sv
// ----------------------------------------------------------------------------
// Linear-probing hash table package
// Shared field widths, command and status codes, and the slot word type.
// ----------------------------------------------------------------------------
package lpht_pkg;

    localparam int CMD_W   = 2;
    localparam int KEY_W   = 64;
    localparam int MEMO_W  = 64;
    localparam int SIDX_W  = 10;
    localparam int LINE_W  = 16;
    localparam int STAT_W  = 3;
    localparam int MOVED_W = 10;
    localparam int LCNT_W  = 9;

    localparam logic [LINE_W-1:0] NO_LINE = 16'hFFFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_QUERY  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 3'd0,
        ST_MISS    = 3'd1,
        ST_CORRUPT = 3'd2,
        ST_EXISTS  = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    typedef struct packed {
        logic              used;
        logic [MEMO_W-1:0] memo;
        logic [KEY_W-1:0]  key;
        logic [LINE_W-1:0] line;
    } t_slot;

endpackage

FILE: rtl/core/lpht_if.sv
// ----------------------------------------------------------------------------
// Linear-probing hash table channels
// Command and result channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface lpht_cmd_if import lpht_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [KEY_W-1:0]  key;
    logic [MEMO_W-1:0] memo;
    logic [SIDX_W-1:0] slot_index;
    logic [LINE_W-1:0] line_index;

    modport source (output valid, cmd, key, memo, slot_index, line_index, input ready);
    modport sink (input valid, cmd, key, memo, slot_index, line_index, output ready);
endinterface

interface lpht_res_if import lpht_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic [SIDX_W-1:0]  slot;
    logic [LINE_W-1:0]  entry_line;
    logic [MOVED_W-1:0] moved_count;

    modport source (output valid, status, slot, entry_line, moved_count, input ready);
    modport sink (input valid, status, slot, entry_line, moved_count, output ready);
endinterface

FILE: rtl/core/linear_probe_hash_table_core.sv
// ----------------------------------------------------------------------------
// Linear-probing hash table core
// Query, insert, backward-shift remove and line back-pointer read on a
// power-of-two table held in one slot memory and one back-pointer memory.
// ----------------------------------------------------------------------------
// Usage: one command word enters on i_cmd_ch and gives exactly one result
// word on o_res_ch. The block takes a command only while its sequencer is
// idle; the result sits in an output register, so a new command may be
// taken while the previous result still waits for the receiver.
// The slot memory has a single read port. A query or insert reads one probed
// slot at a time until it finds a match or an empty slot. A remove reads the
// run up to the first empty slot, then reads each following slot of the run
// again and looks up the back-pointer of each shifted entry with a tracked
// line; a remove of an unused slot ends after one read. A line read looks up
// the back-pointer and then the slot; an untracked line gives a miss with no read.
// A stalled receiver holds the finished result and the sequencer waits
// before writing the next one.
// After reset the block sweeps the slot memory, one slot a cycle, and clears
// every slot before it takes a command; line_count writes are taken
// at any time through i_cfg_we and i_cfg_wdata.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_core
    import lpht_pkg::*;
#(
    parameter int TABLE_SLOTS = 1024,
    parameter int LINE_COUNT  = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [LCNT_W-1:0] i_cfg_wdata,
    lpht_cmd_if.sink          i_cmd_ch,
    lpht_res_if.source        o_res_ch
);

    localparam int SW  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int LAW = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
    localparam logic [SW-1:0] SLOT_LAST = SW'(TABLE_SLOTS - 1);
    localparam logic [SW:0]   FULL_CNT  = (SW + 1)'(TABLE_SLOTS - 1);
    localparam logic [16:0]   LINE_MAX  = 17'(LINE_COUNT);

    typedef enum logic [14:0] {
        S_CLEAR  = 15'b000000000000001,
        S_IDLE   = 15'b000000000000010,
        S_P_RD   = 15'b000000000000100,
        S_P_CHK  = 15'b000000000001000,
        S_R_RD   = 15'b000000000010000,
        S_R_CHK  = 15'b000000000100000,
        S_S_RD   = 15'b000000001000000,
        S_S_CHK  = 15'b000000010000000,
        S_SH_NX  = 15'b000000100000000,
        S_SH_CHK = 15'b000001000000000,
        S_SH_LS  = 15'b000010000000000,
        S_LN_RD  = 15'b000100000000000,
        S_LN_MID = 15'b001000000000000,
        S_LN_CHK = 15'b010000000000000,
        S_FIN    = 15'b100000000000000
    } t_state;

    t_slot           slot_mem [TABLE_SLOTS];
    logic [SW-1:0]   line_mem [LINE_COUNT];

    t_state            r_state, n_state;
    logic [LCNT_W-1:0] r_line_count;
    t_cmd              r_cmd, n_cmd;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [MEMO_W-1:0] r_memo, n_memo;
    logic [SW-1:0]     r_sidx, n_sidx;
    logic [LINE_W-1:0] r_lidx, n_lidx;
    logic [SW-1:0]     r_idx, n_idx;
    logic [SW-1:0]     r_n, n_n;
    logic [SW-1:0]     r_hole, n_hole;
    logic [SW-1:0]     r_end, n_end;
    logic [SW-1:0]     r_moved, n_moved;
    logic [LINE_W-1:0] r_gone, n_gone;
    t_status           r_st, n_st;
    logic [SW-1:0]     r_rslot, n_rslot;
    logic [LINE_W-1:0] r_rline, n_rline;
    logic [SW:0]       r_count, n_count;
    logic [SW-1:0]     r_clr, n_clr;
    t_slot             r_ent, n_ent;
    logic              r_ov, n_ov;
    logic [STAT_W-1:0] r_o_status;
    logic [SW-1:0]     r_o_slot, r_o_moved;
    logic [LINE_W-1:0] r_o_line;
    t_slot             r_mq;
    logic [SW-1:0]     r_lq;

    logic              mem_we;
    logic [SW-1:0]     mem_wa, mem_ra;
    t_slot             mem_wd;
    logic              ls_we;
    logic [LAW-1:0]    ls_wa, ls_ra;
    logic [SW-1:0]     ls_wd;
    logic [16:0]       w_lines;
    logic              w_accept, w_out_load;
    logic [SW+9:0]     w_sidx_ext, w_slot_ext, w_moved_ext;
    logic [SW-1:0]     w_home, w_dh, w_dc, w_next;

    assign w_lines = ({8'd0, r_line_count} > LINE_MAX) ? LINE_MAX : {8'd0, r_line_count};
    assign w_accept = i_cmd_ch.valid && i_cmd_ch.ready;
    assign w_sidx_ext = {{SW{1'b0}}, i_cmd_ch.slot_index};
    assign w_home = r_mq.memo[SW-1:0];
    assign w_dh = w_home - r_hole;
    assign w_dc = r_idx - r_hole;
    assign w_next = r_idx + 1'b1;

    assign i_cmd_ch.ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cmd = r_cmd;
        n_key = r_key;
        n_memo = r_memo;
        n_sidx = r_sidx;
        n_lidx = r_lidx;
        n_idx = r_idx;
        n_n = r_n;
        n_hole = r_hole;
        n_end = r_end;
        n_moved = r_moved;
        n_gone = r_gone;
        n_st = r_st;
        n_rslot = r_rslot;
        n_rline = r_rline;
        n_count = r_count;
        n_clr = r_clr;
        n_ent = r_ent;
        n_ov = r_ov && !o_res_ch.ready;
        w_out_load = 1'b0;
        mem_we = 1'b0;
        mem_wa = r_hole;
        mem_wd = r_ent;
        mem_ra = r_idx;
        ls_we = 1'b0;
        ls_wa = r_ent.line[LAW-1:0];
        ls_wd = r_hole;
        ls_ra = r_lidx[LAW-1:0];
        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
                mem_wd = '0;
                n_clr = r_clr + 1'b1;
                if (r_clr == SLOT_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd = t_cmd'(i_cmd_ch.cmd);
                    n_key = i_cmd_ch.key;
                    n_memo = i_cmd_ch.memo;
                    n_sidx = w_sidx_ext[SW-1:0];
                    n_lidx = i_cmd_ch.line_index;
                    n_idx = i_cmd_ch.memo[SW-1:0];
                    n_n = '0;
                    n_moved = '0;
                    case (t_cmd'(i_cmd_ch.cmd))
                        CMD_QUERY, CMD_INSERT: begin
                            n_state = S_P_RD;
                        end
                        CMD_REMOVE: begin
                            n_state = S_R_RD;
                        end
                        default: begin
                            if ({1'b0, i_cmd_ch.line_index} >= w_lines) begin
                                n_st = ST_MISS;
                                n_rslot = '0;
                                n_rline = NO_LINE;
                                n_state = S_FIN;
                            end else begin
                                n_state = S_LN_RD;
                            end
                        end
                    endcase
                end
            end
            S_P_RD: begin
                n_state = S_P_CHK;
            end
            S_P_CHK: begin
                n_rslot = r_idx;
                n_rline = NO_LINE;
                n_state = S_FIN;
                if (!r_mq.used) begin
                    if (r_cmd != CMD_INSERT) begin
                        n_st = ST_MISS;
                    end else if (r_count >= FULL_CNT) begin
                        n_st = ST_FULL;
                    end else begin
                        n_st = ST_OK;
                        n_rline = r_lidx;
                        mem_we = 1'b1;
                        mem_wa = r_idx;
                        mem_wd = '{used: 1'b1, memo: r_memo, key: r_key, line: r_lidx};
                        if ({1'b0, r_lidx} < w_lines) begin
                            ls_we = 1'b1;
                            ls_wa = r_lidx[LAW-1:0];
                            ls_wd = r_idx;
                        end
                        n_count = r_count + 1'b1;
                    end
                end else if (r_mq.memo == r_memo && r_mq.key == r_key) begin
                    n_st = (r_cmd == CMD_INSERT) ? ST_EXISTS : ST_OK;
                    n_rline = r_mq.line;
                end else begin
                    n_idx = w_next;
                    if (r_n == SLOT_LAST) begin
                        n_st = ST_CORRUPT;
                        n_rslot = w_next;
                    end else begin
                        n_n = r_n + 1'b1;
                        n_state = S_P_RD;
                    end
                end
            end
            S_R_RD: begin
                mem_ra = r_sidx;
                n_state = S_R_CHK;
            end
            S_R_CHK: begin
                n_rslot = r_sidx;
                if (!r_mq.used) begin
                    n_st = ST_MISS;
                    n_rline = NO_LINE;
                    n_state = S_FIN;
                end else begin
                    n_gone = r_mq.line;
                    n_idx = r_sidx + 1'b1;
                    n_n = SW'(1);
                    n_state = S_S_RD;
                end
            end
            S_S_RD: begin
                n_state = S_S_CHK;
            end
            S_S_CHK: begin
                if (!r_mq.used) begin
                    n_end = r_idx;
                    mem_we = 1'b1;
                    mem_wa = r_sidx;
                    mem_wd = '0;
                    if (r_count != '0) begin
                        n_count = r_count - 1'b1;
                    end
                    n_hole = r_sidx;
                    n_idx = r_sidx;
                    n_st = ST_OK;
                    n_state = S_SH_NX;
                end else if (r_n == SLOT_LAST) begin
                    n_st = ST_CORRUPT;
                    n_rline = r_gone;
                    n_state = S_FIN;
                end else begin
                    n_n = r_n + 1'b1;
                    n_idx = w_next;
                    n_state = S_S_RD;
                end
            end
            S_SH_NX: begin
                if (w_next == r_end) begin
                    if (r_moved != '0) begin
                        mem_we = 1'b1;
                        mem_wa = r_hole;
                        mem_wd = '0;
                    end
                    n_rline = r_gone;
                    n_state = S_FIN;
                end else begin
                    n_idx = w_next;
                    mem_ra = w_next;
                    n_state = S_SH_CHK;
                end
            end
            S_SH_CHK: begin
                n_ent = r_mq;
                n_ent.used = 1'b1;
                if (w_dh != '0 && w_dh <= w_dc) begin
                    n_state = S_SH_NX;
                end else if ({1'b0, r_mq.line} < w_lines) begin
                    ls_ra = r_mq.line[LAW-1:0];
                    n_state = S_SH_LS;
                end else begin
                    if (r_mq.line != NO_LINE) begin
                        n_st = ST_CORRUPT;
                    end
                    mem_we = 1'b1;
                    mem_wa = r_hole;
                    mem_wd = r_mq;
                    mem_wd.used = 1'b1;
                    n_hole = r_idx;
                    n_moved = r_moved + 1'b1;
                    n_state = S_SH_NX;
                end
            end
            S_SH_LS: begin
                if (r_lq != r_idx) begin
                    n_st = ST_CORRUPT;
                end
                ls_we = 1'b1;
                mem_we = 1'b1;
                n_hole = r_idx;
                n_moved = r_moved + 1'b1;
                n_state = S_SH_NX;
            end
            S_LN_RD: begin
                n_state = S_LN_MID;
            end
            S_LN_MID: begin
                n_idx = r_lq;
                mem_ra = r_lq;
                n_state = S_LN_CHK;
            end
            S_LN_CHK: begin
                n_st = (r_mq.used && r_mq.line == r_lidx) ? ST_OK : ST_CORRUPT;
                n_rslot = r_idx;
                n_rline = r_lidx;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_ov || o_res_ch.ready) begin
                    n_ov = 1'b1;
                    w_out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            slot_mem[mem_wa] <= mem_wd;
        end
        r_mq <= slot_mem[mem_ra];
        if (ls_we) begin
            line_mem[ls_wa] <= ls_wd;
        end
        r_lq <= line_mem[ls_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_line_count <= '0;
            r_count <= '0;
            r_clr <= '0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_line_count <= i_cfg_wdata;
            end
            r_count <= n_count;
            r_clr <= n_clr;
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_key <= n_key;
        r_memo <= n_memo;
        r_sidx <= n_sidx;
        r_lidx <= n_lidx;
        r_idx <= n_idx;
        r_n <= n_n;
        r_hole <= n_hole;
        r_end <= n_end;
        r_moved <= n_moved;
        r_gone <= n_gone;
        r_st <= n_st;
        r_rslot <= n_rslot;
        r_rline <= n_rline;
        r_ent <= n_ent;
        if (w_out_load) begin
            r_o_status <= r_st;
            r_o_slot <= (r_cmd == CMD_REMOVE) ? r_sidx : r_rslot;
            r_o_line <= r_rline;
            r_o_moved <= r_moved;
        end
    end

    assign w_slot_ext = {10'd0, r_o_slot};
    assign w_moved_ext = {10'd0, r_o_moved};

    assign o_res_ch.valid = r_ov;
    assign o_res_ch.status = r_o_status;
    assign o_res_ch.slot = w_slot_ext[9:0];
    assign o_res_ch.entry_line = r_o_line;
    assign o_res_ch.moved_count = w_moved_ext[9:0];

endmodule
